FILE: sv/cdes_pkg.sv
// ----------------------------------------------------------------------------
// cdes_pkg
// Shared types, constants and the month table for the civil date to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package cdes_pkg;

   localparam int YearWidth    = 14;
   localparam int MonthWidth   = 4;
   localparam int DayWidth     = 5;
   localparam int HourWidth    = 5;
   localparam int MinuteWidth  = 6;
   localparam int SecondWidth  = 6;
   localparam int EpochWidth   = 38;

   localparam int DaysWidth    = 23;
   localparam int TodWidth     = 17;
   localparam int ProdWidth    = 39;
   localparam int SumWidth     = 40;
   localparam int MonthDaysWidth = 9;

   localparam logic [YearWidth-1:0] EpochYear        = 14'd1970;
   localparam logic [23:0]          LeapsBeforeEpoch = 24'd477;
   localparam logic [11:0]          Recip25          = 12'd2622;
   localparam logic [16:0]          SecsPerDay       = 17'd86400;
   localparam logic [SumWidth-1:0]  OutMax           = {{(SumWidth-EpochWidth){1'b0}},
                                                        {EpochWidth{1'b1}}};

   typedef struct packed {
      logic s1;
      logic s2;
   } year_en_type;

   function automatic logic [MonthDaysWidth-1:0] days_before_month(
      input logic [MonthWidth-1:0] month
   );
      logic [MonthDaysWidth-1:0] days;
      unique case (month)
         4'd0, 4'd1: days = 9'd0;
         4'd2:       days = 9'd31;
         4'd3:       days = 9'd59;
         4'd4:       days = 9'd90;
         4'd5:       days = 9'd120;
         4'd6:       days = 9'd151;
         4'd7:       days = 9'd181;
         4'd8:       days = 9'd212;
         4'd9:       days = 9'd243;
         4'd10:      days = 9'd273;
         4'd11:      days = 9'd304;
         default:    days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

FILE: sv/cdes_if.sv
// ----------------------------------------------------------------------------
// cdes_req_if / cdes_rsp_if
// Valid/ready channels for the date input and the seconds result.
// ----------------------------------------------------------------------------
interface cdes_req_if;
   logic                               valid;
   logic                               ready;
   logic [cdes_pkg::YearWidth-1:0]     year;
   logic [cdes_pkg::MonthWidth-1:0]    month;
   logic [cdes_pkg::DayWidth-1:0]      day;
   logic [cdes_pkg::HourWidth-1:0]     hour;
   logic [cdes_pkg::MinuteWidth-1:0]   minute;
   logic [cdes_pkg::SecondWidth-1:0]   second;

   modport source (output valid, year, month, day, hour, minute, second, input ready);
   modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface cdes_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cdes_pkg::EpochWidth-1:0]    epoch_seconds;

   modport source (output valid, epoch_seconds, input ready);
   modport sink   (input valid, epoch_seconds, output ready);
endinterface

FILE: sv/cdes_year_days.sv
// ----------------------------------------------------------------------------
// cdes_year_days
// Two register stages that turn a year into the day count of the whole
// years since 1970 and the leap flag of the year itself.
// ----------------------------------------------------------------------------
module cdes_year_days (
   input  logic                               clock,
   input  cdes_pkg::year_en_type              en,
   input  logic [cdes_pkg::YearWidth-1:0]     year,
   output logic [cdes_pkg::DaysWidth-1:0]     days_years,
   output logic                               leap
);

   // Stage one: reciprocal products for the divisions by 25.
   logic [cdes_pkg::YearWidth-1:0] ym1;
   logic [cdes_pkg::YearWidth-1:0] yoff_in, yoff_ff;
   logic                           span_in, span_ff;
   logic [11:0]                    quarter_in, quarter_ff;
   logic [23:0]                    pb_in, pb_ff;
   logic [23:0]                    pc_in, pc_ff;
   logic [11:0]                    xq_in, xq_ff;
   logic [23:0]                    pl_in, pl_ff;
   logic                           four_in, four_ff;

   assign ym1        = year - 14'd1;
   assign span_in    = year > cdes_pkg::EpochYear;
   assign yoff_in    = year - cdes_pkg::EpochYear;
   assign quarter_in = ym1[13:2];
   assign pb_in      = 24'(ym1[13:2]) * 24'(cdes_pkg::Recip25);
   assign pc_in      = 24'(ym1[13:4]) * 24'(cdes_pkg::Recip25);
   assign xq_in      = year[13:2];
   assign pl_in      = 24'(year[13:2]) * 24'(cdes_pkg::Recip25);
   assign four_in    = year[1:0] == 2'd0;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         span_ff    <= span_in;
         yoff_ff    <= yoff_in;
         quarter_ff <= quarter_in;
         pb_ff      <= pb_in;
         pc_ff      <= pc_in;
         xq_ff      <= xq_in;
         pl_ff      <= pl_in;
         four_ff    <= four_in;
      end
   end

   // Stage two: leap count difference and the Gregorian leap test.
   logic [7:0]                     cent;
   logic [7:0]                     quad;
   logic [7:0]                     q25;
   logic [11:0]                    r25;
   logic [23:0]                    total;
   logic [cdes_pkg::DaysWidth-1:0] days_in, days_ff;
   logic                           leap_in, leap_ff;

   assign cent  = pb_ff[23:16];
   assign quad  = pc_ff[23:16];
   assign q25   = pl_ff[23:16];
   assign r25   = xq_ff - 12'(q25) * 12'd25;
   assign total = 24'(yoff_ff) * 24'd365 + 24'(quarter_ff) + 24'(quad) - 24'(cent)
                  - cdes_pkg::LeapsBeforeEpoch;
   assign days_in = span_ff ? total[cdes_pkg::DaysWidth-1:0] : '0;
   assign leap_in = four_ff && ((r25 != 12'd0) || (q25[1:0] == 2'd0));

   always_ff @(posedge clock) begin
      if (en.s2) begin
         days_ff <= days_in;
         leap_ff <= leap_in;
      end
   end

   assign days_years = days_ff;
   assign leap       = leap_ff;

endmodule

FILE: sv/civil_date_to_epoch_seconds_unit.sv
// ----------------------------------------------------------------------------
// civil_date_to_epoch_seconds_unit
// Converts a civil date and time from 1970 onward into seconds since
// 1970-01-01 00:00:00, with no time zone.
// ----------------------------------------------------------------------------
// A date beat enters on req (year, month, day, hour, minute, second) and
// the matching count of seconds leaves on rsp as epoch_seconds, one result
// beat per date beat, in order. Months above twelve count as December,
// days and time fields past their range add linearly, a total below zero
// gives zero and a total above 38 bits saturates.
// The pipeline has six register stages: year reciprocal products, leap
// count and leap test, day sum, the multiply by 86400, the time of day
// add, and the output register. A date beat passes through them in this
// order, and rsp.valid is the valid flag of the output register. A new
// beat can be taken in every cycle unless all stages are full and rsp stalls.
// Each stage loads when it is empty or its successor loads, so bubbles
// close up while rsp stalls; req.ready falls only once all six stages
// hold a beat and rsp.ready is low. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module civil_date_to_epoch_seconds_unit (
   input  logic              clock,
   input  logic              reset,
   cdes_req_if.sink          req,
   cdes_rsp_if.source        rsp
);

   localparam int Stages = 6;

   logic [Stages:1] valid_ff, valid_in;
   logic [Stages:1] load;

   always_comb begin
      load[Stages] = !valid_ff[Stages] || rsp.ready;
      for (int k = Stages - 1; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[1] = load[1] ? req.valid : valid_ff[1];
      for (int k = 2; k <= Stages; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req.ready = load[1];

   // Year terms over stages one and two.
   cdes_pkg::year_en_type            year_en;
   logic [cdes_pkg::DaysWidth-1:0]   days_years;
   logic                             leap;

   assign year_en.s1 = load[1];
   assign year_en.s2 = load[2];

   cdes_year_days u_year_days (
      .clock      (clock),
      .en         (year_en),
      .year       (req.year),
      .days_years (days_years),
      .leap       (leap)
   );

   // Stage one: month table and time of day.
   logic [cdes_pkg::MonthDaysWidth-1:0] dbm1_ff, dbm2_ff;
   logic                                late1_ff, late2_ff;
   logic [cdes_pkg::DayWidth-1:0]       day1_ff, day2_ff;
   logic [cdes_pkg::TodWidth-1:0]       tod_in;
   logic [cdes_pkg::TodWidth-1:0]       tod1_ff, tod2_ff, tod3_ff, tod4_ff;

   assign tod_in = 17'(req.hour) * 17'd3600 + 17'(req.minute) * 17'd60 + 17'(req.second);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         dbm1_ff  <= cdes_pkg::days_before_month(req.month);
         late1_ff <= req.month > 4'd2;
         day1_ff  <= req.day;
         tod1_ff  <= tod_in;
      end
      if (load[2]) begin
         dbm2_ff  <= dbm1_ff;
         late2_ff <= late1_ff;
         day2_ff  <= day1_ff;
         tod2_ff  <= tod1_ff;
      end
   end

   // Stage three: total day count.
   logic [cdes_pkg::DaysWidth-1:0] days_in, days3_ff;

   assign days_in = days_years + 23'(dbm2_ff) + 23'(day2_ff) + 23'(late2_ff && leap);

   always_ff @(posedge clock) begin
      if (load[3]) begin
         days3_ff <= days_in;
         tod3_ff  <= tod2_ff;
      end
   end

   // Stage four: days to seconds.
   logic [cdes_pkg::ProdWidth-1:0] prod_in, prod4_ff;

   assign prod_in = 39'(days3_ff) * 39'(cdes_pkg::SecsPerDay);

   always_ff @(posedge clock) begin
      if (load[4]) begin
         prod4_ff <= prod_in;
         tod4_ff  <= tod3_ff;
      end
   end

   // Stage five: add the time of day.
   logic [cdes_pkg::SumWidth-1:0] sum_in, sum5_ff;

   assign sum_in = 40'(prod4_ff) + 40'(tod4_ff);

   always_ff @(posedge clock) begin
      if (load[5]) begin
         sum5_ff <= sum_in;
      end
   end

   // Stage six: take back the first day, floor at zero, saturate.
   logic [cdes_pkg::SumWidth-1:0]   back;
   logic [cdes_pkg::EpochWidth-1:0] out_in, out_ff;

   always_comb begin
      if (sum5_ff >= 40'(cdes_pkg::SecsPerDay)) begin
         back = sum5_ff - 40'(cdes_pkg::SecsPerDay);
      end else begin
         back = '0;
      end
      if (back > cdes_pkg::OutMax) begin
         out_in = cdes_pkg::OutMax[cdes_pkg::EpochWidth-1:0];
      end else begin
         out_in = back[cdes_pkg::EpochWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid         = valid_ff[Stages];
   assign rsp.epoch_seconds = out_ff;

   // The pipeline refuses a beat only when every stage is full and stalled.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (valid_ff == '1) && !rsp.ready)
      else $error("input stalled while the pipeline has room");

   // An accepted beat always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> valid_ff[1])
      else $error("accepted beat lost at the first stage");

   // A held result beat is not dropped by the last stage.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(out_ff))
      else $error("stalled result changed");

   // The pipeline is empty right after reset.
   assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

FILE: test/epoch_seconds_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_checker
// Watches the date and result channels of the converter, works out the
// seconds count for every date beat taken and compares each result beat
// against the oldest outstanding count. It reports the number of failures
// and the number of counts still outstanding.
// ----------------------------------------------------------------------------
module epoch_seconds_checker (
   input  logic   clock,
   input  logic   reset,
   cdes_req_if    req,
   cdes_rsp_if    rsp,
   output int     failures,
   output int     pending
);

   localparam longint unsigned DaySeconds     = 64'd86400;
   localparam longint unsigned SecondsCeiling = (64'd1 << cdes_pkg::EpochWidth) - 64'd1;
   localparam int unsigned     MonthStart [13] = '{
      0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
   };

   logic [cdes_pkg::EpochWidth-1:0] expected_seconds [$];
   int                              mismatch_count = 0;
   int                              outstanding = 0;

   assign failures = mismatch_count;
   assign pending  = outstanding;

   function automatic longint unsigned leap_years_through(input longint unsigned y);
      return y / 4 - y / 100 + y / 400;
   endfunction

   function automatic logic [cdes_pkg::EpochWidth-1:0] epoch_seconds_of(
      input logic [cdes_pkg::YearWidth-1:0]   year,
      input logic [cdes_pkg::MonthWidth-1:0]  month,
      input logic [cdes_pkg::DayWidth-1:0]    day,
      input logic [cdes_pkg::HourWidth-1:0]   hour,
      input logic [cdes_pkg::MinuteWidth-1:0] minute,
      input logic [cdes_pkg::SecondWidth-1:0] second
   );
      longint unsigned y;
      longint unsigned m;
      longint unsigned days;
      longint unsigned total;
      y = year;
      m = (month > 12) ? 12 : month;
      days = 0;
      if (y > cdes_pkg::EpochYear) begin
         days = 365 * (y - cdes_pkg::EpochYear) + leap_years_through(y - 1)
              - leap_years_through(cdes_pkg::EpochYear - 1);
      end
      days += MonthStart[m];
      if (m > 2 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) begin
         days += 1;
      end
      days += day;
      total = days * DaySeconds + longint'(hour) * 3600 + longint'(minute) * 60
            + longint'(second);
      // Days count from 1, so one day comes off, never going below zero.
      if (total >= DaySeconds) begin
         total -= DaySeconds;
      end else begin
         total = 0;
      end
      if (total > SecondsCeiling) begin
         total = SecondsCeiling;
      end
      return total[cdes_pkg::EpochWidth-1:0];
   endfunction

   always @(posedge clock) begin
      logic [cdes_pkg::EpochWidth-1:0] wanted;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (expected_seconds.size() == 0) begin
               $display("%0t: epoch_seconds expected none, got %0d", $time,
                        rsp.epoch_seconds);
               mismatch_count++;
            end else begin
               wanted = expected_seconds.pop_front();
               if (rsp.epoch_seconds !== wanted) begin
                  $display("%0t: epoch_seconds expected %0d, got %0d", $time,
                           wanted, rsp.epoch_seconds);
                  mismatch_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            expected_seconds.push_back(epoch_seconds_of(req.year, req.month, req.day,
                                                        req.hour, req.minute,
                                                        req.second));
         end
         outstanding <= expected_seconds.size();
      end
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives dates into the civil date to epoch seconds converter and gives the
// verdict. A directed set covers the calendar edges, leap rules and fields
// out of range, then random dates run through phases of sender idling,
// receiver stalls and one long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [cdes_pkg::YearWidth-1:0]   year;
      logic [cdes_pkg::MonthWidth-1:0]  month;
      logic [cdes_pkg::DayWidth-1:0]    day;
      logic [cdes_pkg::HourWidth-1:0]   hour;
      logic [cdes_pkg::MinuteWidth-1:0] minute;
      logic [cdes_pkg::SecondWidth-1:0] second;
   } civil_date_type;

   localparam int PhaseDates = 130;
   localparam int HoldCycles = 80;

   logic clock;
   logic reset = 1'b1;
   logic hold_request = 1'b0;
   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   int   failures;
   int   pending;

   cdes_req_if req_ch ();
   cdes_rsp_if rsp_ch ();

   civil_date_to_epoch_seconds_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   epoch_seconds_checker checker_inst (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
                                              input int width);
      if ($urandom_range(99) < 15) begin
         return $urandom_range((1 << width) - 1, 0);
      end
      return $urandom_range(hi, lo);
   endfunction

   function automatic civil_date_type random_date();
      civil_date_type d;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: d.year = 14'($urandom_range(9999, 1970));
         5:             d.year = 14'(100 * $urandom_range(99, 20) + $urandom_range(4));
         6:             d.year = 14'($urandom_range(1979, 1970));
         7:             d.year = 14'($urandom_range(16383, 10000));
         8:             d.year = 14'($urandom_range(16383, 0));
         default:       d.year = 14'($urandom_range(1969, 0));
      endcase
      d.month  = 4'(pick_field(1, 12, cdes_pkg::MonthWidth));
      d.day    = 5'(pick_field(1, 31, cdes_pkg::DayWidth));
      d.hour   = 5'(pick_field(0, 23, cdes_pkg::HourWidth));
      d.minute = 6'(pick_field(0, 59, cdes_pkg::MinuteWidth));
      d.second = 6'(pick_field(0, 59, cdes_pkg::SecondWidth));
      return d;
   endfunction

   task automatic send(input civil_date_type d);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_ch.valid  <= 1'b1;
      req_ch.year   <= d.year;
      req_ch.month  <= d.month;
      req_ch.day    <= d.day;
      req_ch.hour   <= d.hour;
      req_ch.minute <= d.minute;
      req_ch.second <= d.second;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic send_date(input int unsigned year, input int unsigned month,
                            input int unsigned day, input int unsigned hour,
                            input int unsigned minute, input int unsigned second);
      civil_date_type d;
      d.year   = 14'(year);
      d.month  = 4'(month);
      d.day    = 5'(day);
      d.hour   = 5'(hour);
      d.minute = 6'(minute);
      d.second = 6'(second);
      send(d);
   endtask

   initial begin : result_side
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            stall_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin : date_side
      int phase;
      int k;
      req_ch.valid  <= 1'b0;
      req_ch.year   <= '0;
      req_ch.month  <= '0;
      req_ch.day    <= '0;
      req_ch.hour   <= '0;
      req_ch.minute <= '0;
      req_ch.second <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_date(1970, 1, 1, 0, 0, 0);
      send_date(1970, 1, 0, 0, 0, 0);
      send_date(1970, 1, 0, 23, 59, 59);
      send_date(1970, 1, 2, 0, 0, 0);
      send_date(1969, 3, 1, 0, 0, 0);
      send_date(1968, 3, 1, 0, 0, 0);
      send_date(0, 12, 31, 23, 59, 59);
      send_date(0, 0, 0, 0, 0, 0);
      send_date(1971, 1, 1, 0, 0, 0);
      send_date(1972, 3, 1, 0, 0, 0);
      send_date(2000, 2, 29, 12, 0, 0);
      send_date(2000, 3, 1, 0, 0, 0);
      send_date(2100, 3, 1, 0, 0, 0);
      send_date(2400, 12, 31, 0, 0, 0);
      send_date(1999, 12, 31, 23, 59, 59);
      send_date(2038, 1, 19, 3, 14, 7);
      send_date(2024, 0, 15, 12, 0, 0);
      send_date(2024, 13, 1, 0, 0, 0);
      send_date(2023, 15, 1, 0, 0, 0);
      send_date(1970, 2, 31, 0, 0, 0);
      send_date(1970, 1, 1, 31, 63, 63);
      send_date(9999, 12, 31, 23, 59, 59);
      send_date(12000, 1, 1, 0, 0, 0);
      send_date(16383, 15, 31, 31, 63, 63);

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct = 68;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 68;
            end
            3: begin
               sender_idle_pct = 32;
               receiver_stall_pct <= 32;
            end
            default: begin
               // The receiver holds off while dates keep coming every cycle.
               sender_idle_pct = 0;
               receiver_stall_pct <= 0;
               hold_request <= 1'b1;
            end
         endcase
         for (k = 0; k < PhaseDates; k++) begin
            send(random_date());
         end
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      for (k = 0; k < 2000 && pending != 0; k++) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
